### sv/fbrf_pkg.sv
// Shared types and constants for the rectangle fill blitter.
package fbrf_pkg;

   localparam int CoordW = 11;   // on-screen coordinate and extent width
   localparam int FieldW = 12;   // signed coordinate field width
   localparam int ColorW = 16;
   localparam int FuncW  = 2;
   localparam int QueueDepth = 4;

   localparam logic [FuncW-1:0] FUNC_SET   = 2'd0;
   localparam logic [FuncW-1:0] FUNC_FILL  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_CLEAR = 2'd2;
   localparam logic [FuncW-1:0] FUNC_READ  = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_DONE
   } st_type;

   // Classified command; the start address travels beside it.
   typedef struct packed {
      op_type              op;
      logic                oor;
      logic [ColorW-1:0]   color;
      logic [CoordW-1:0]   wcnt;
      logic [CoordW-1:0]   hcnt;
   } cmd_type;

endpackage

### sv/framebuffer_rect_fill.sv
// Top level of the rectangle fill blitter over a SCREEN_W by SCREEN_H pixel store.
// Usage:
//   The req_ channel carries one command per item: set pixel, fill rectangle,
//   clear screen or read pixel, with edges and a 16-bit color. The rsp_
//   channel returns exactly one item per command, in order: the pixel color
//   for a read (zero otherwise) and an out-of-range flag for a set or read
//   off the screen.
//   An item enters a classify/clamp register, then a four-entry command
//   queue, then the raster engine, which writes one pixel per cycle.
//   Set and read pass through ST_FILL or ST_READ, while off-screen commands and
//   empty fills go straight to ST_DONE; a fill writes its clamped width times
//   height pixels, a clear all SCREEN_W*SCREEN_H (153600 at 480 by 320).
//   Throughput is set by the raster engine and its single store write port:
//   one command at a time, one pixel per cycle.
//   Short commands can be taken while a long fill runs, until the queue fills.
//   Reset clears control state only; pixel contents are undefined until
//   written, and no clearing pass runs.
//   When the receiver stalls, the result holds in the output register, the
//   engine waits with the next result and the queue backs up to req_stall.
module framebuffer_rect_fill import fbrf_pkg::*; #(
   parameter int SCREEN_W = 480,
   parameter int SCREEN_H = 320
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FuncW-1:0]         req_func,
   input  logic signed [FieldW-1:0] req_x_left,
   input  logic signed [FieldW-1:0] req_y_top,
   input  logic signed [FieldW-1:0] req_x_right,
   input  logic signed [FieldW-1:0] req_y_bottom,
   input  logic [ColorW-1:0]        req_pixel_color,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ColorW-1:0]        rsp_read_data,
   output logic                     rsp_out_of_range
);

   localparam int Depth = SCREEN_W * SCREEN_H;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW    = $bits(cmd_type);
   localparam int DW    = CW + AW;

   logic          push_valid, queue_full, queue_empty, pop;
   cmd_type       push_cmd, head_cmd;
   logic [AW-1:0] push_addr, head_addr;
   logic [DW-1:0] head_data;

   assign head_cmd  = cmd_type'(head_data[DW-1:AW]);
   assign head_addr = head_data[AW-1:0];

   fbrf_front #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_x_left(req_x_left),
      .req_y_top(req_y_top),
      .req_x_right(req_x_right),
      .req_y_bottom(req_y_bottom),
      .req_pixel_color(req_pixel_color),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .push_addr(push_addr),
      .queue_full(queue_full)
   );

   fbrf_queue #(
      .DW(DW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_data({push_cmd, push_addr}),
      .full(queue_full),
      .pop(pop),
      .head_data(head_data),
      .empty(queue_empty)
   );

   fbrf_back #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H),
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .head_cmd(head_cmd),
      .head_addr(head_addr),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_out_of_range(rsp_out_of_range)
   );

endmodule

### sv/fbrf_front.sv
// Front end: accepts items, classifies and clamps them, computes the start address.
module fbrf_front import fbrf_pkg::*; #(
   parameter int SCREEN_W = 480,
   parameter int SCREEN_H = 320,
   parameter int AW = 18
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FuncW-1:0]         req_func,
   input  logic signed [FieldW-1:0] req_x_left,
   input  logic signed [FieldW-1:0] req_y_top,
   input  logic signed [FieldW-1:0] req_x_right,
   input  logic signed [FieldW-1:0] req_y_bottom,
   input  logic [ColorW-1:0]        req_pixel_color,
   output logic                     push_valid,
   output cmd_type                  push_cmd,
   output logic [AW-1:0]            push_addr,
   input  logic                     queue_full
);

   localparam logic signed [FieldW-1:0] WS = FieldW'(SCREEN_W);
   localparam logic signed [FieldW-1:0] HS = FieldW'(SCREEN_H);

   logic                      a_valid_ff, a_valid_in;
   cmd_type                   a_cmd_ff, a_cmd_in;
   logic [CoordW-1:0]         a_l_ff, a_t_ff, l_in, t_in;
   logic signed [FieldW-1:0]  cl_l, cl_t, cl_r, cl_b, dw, dh;
   logic                      on_screen, accept;

   assign req_stall  = a_valid_ff && queue_full;
   assign accept     = req_valid && !req_stall;
   assign push_valid = a_valid_ff && !queue_full;
   assign push_cmd   = a_cmd_ff;
   assign push_addr  = AW'(a_t_ff) * AW'(SCREEN_W) + AW'(a_l_ff);

   always_comb begin
      cl_l = (req_x_left < 0) ? '0 : req_x_left;
      cl_t = (req_y_top < 0) ? '0 : req_y_top;
      cl_r = (req_x_right > WS) ? WS : req_x_right;
      cl_b = (req_y_bottom > HS) ? HS : req_y_bottom;
      dw   = cl_r - cl_l;
      dh   = cl_b - cl_t;
      on_screen = (req_x_left >= 0) && (req_y_top >= 0) &&
                  (req_x_left < WS) && (req_y_top < HS);

      a_cmd_in.color = req_pixel_color;
      a_cmd_in.oor   = 1'b0;
      a_cmd_in.op    = OP_NONE;
      a_cmd_in.wcnt  = CoordW'(1);
      a_cmd_in.hcnt  = CoordW'(1);
      l_in = req_x_left[CoordW-1:0];
      t_in = req_y_top[CoordW-1:0];
      case (req_func)
         FUNC_SET: begin
            a_cmd_in.op  = on_screen ? OP_WRITE : OP_NONE;
            a_cmd_in.oor = !on_screen;
         end
         FUNC_FILL: begin
            a_cmd_in.op   = (cl_l >= cl_r || cl_t >= cl_b) ? OP_NONE : OP_WRITE;
            a_cmd_in.wcnt = dw[CoordW-1:0];
            a_cmd_in.hcnt = dh[CoordW-1:0];
            l_in = cl_l[CoordW-1:0];
            t_in = cl_t[CoordW-1:0];
         end
         FUNC_CLEAR: begin
            a_cmd_in.op   = OP_WRITE;
            a_cmd_in.wcnt = CoordW'(SCREEN_W);
            a_cmd_in.hcnt = CoordW'(SCREEN_H);
            l_in = '0;
            t_in = '0;
         end
         FUNC_READ: begin
            a_cmd_in.op  = on_screen ? OP_READ : OP_NONE;
            a_cmd_in.oor = !on_screen;
         end
         default: begin
            a_cmd_in.op = OP_NONE;
         end
      endcase

      if (accept) a_valid_in = 1'b1;
      else if (push_valid) a_valid_in = 1'b0;
      else a_valid_in = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (accept) begin
         a_cmd_ff <= a_cmd_in;
         a_l_ff   <= l_in;
         a_t_ff   <= t_in;
      end
   end

endmodule

### sv/fbrf_queue.sv
// Short command queue between front and back ends.
module fbrf_queue import fbrf_pkg::*; #(
   parameter int DW = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic [DW-1:0] head_data,
   output logic          empty
);

   localparam int PW = $clog2(QueueDepth);

   logic [DW-1:0] entry_ff [QueueDepth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign full      = (count_ff == (PW+1)'(QueueDepth));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### sv/fbrf_back.sv
// Back end: raster engine over the pixel store, pixel read, result register.
module fbrf_back import fbrf_pkg::*; #(
   parameter int SCREEN_W = 480,
   parameter int SCREEN_H = 320,
   parameter int AW = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  cmd_type           head_cmd,
   input  logic [AW-1:0]     head_addr,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ColorW-1:0] rsp_read_data,
   output logic              rsp_out_of_range
);

   localparam int Depth = SCREEN_W * SCREEN_H;

   logic [ColorW-1:0] frame [Depth];

   st_type            state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in, base_ff, base_in;
   logic [CoordW-1:0] col_ff, col_in, row_ff, row_in;
   cmd_type           cmd_ff;
   logic [ColorW-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ColorW-1:0] rsp_data_ff;
   logic              rsp_oor_ff;
   logic              out_free, row_end, last_row, mem_we, rsp_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign row_end   = (col_ff == cmd_ff.wcnt - 1'b1);
   assign last_row  = (row_ff == cmd_ff.hcnt - 1'b1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               case (head_cmd.op)
                  OP_WRITE: state_in = ST_FILL;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL: if (row_end && last_row) state_in = ST_DONE;
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      pop      = (state_ff == ST_IDLE) && !queue_empty;
      mem_we   = (state_ff == ST_FILL);
      rsp_load = (state_ff == ST_DONE) && out_free;
      addr_in  = addr_ff;
      base_in  = base_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (pop) begin
         addr_in = head_addr;
         base_in = head_addr;
         col_in  = '0;
         row_in  = '0;
      end else if (mem_we) begin
         if (row_end) begin
            // next row starts one screen width below the current row start
            base_in = base_ff + AW'(SCREEN_W);
            addr_in = base_ff + AW'(SCREEN_W);
            col_in  = '0;
            row_in  = row_ff + 1'b1;
         end else begin
            addr_in = addr_ff + 1'b1;
            col_in  = col_ff + 1'b1;
         end
      end
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff <= addr_in;
      base_ff <= base_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      if (pop) cmd_ff <= head_cmd;
      if (rsp_load) begin
         rsp_data_ff <= (cmd_ff.op == OP_READ) ? rd_data_ff : '0;
         rsp_oor_ff  <= cmd_ff.oor;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame[addr_ff] <= cmd_ff.color;
      rd_data_ff <= frame[addr_ff];
   end

endmodule

### tb/sv/tb_framebuffer_rect_fill.sv
// Testbench for the rectangle fill blitter: directed and random commands against a pixel shadow.
module tb_framebuffer_rect_fill import fbrf_pkg::*; ();

   localparam int SCREEN_W = 480;
   localparam int SCREEN_H = 320;
   localparam int RANDOM_ITEMS = 100;

   typedef struct {
      logic [FuncW-1:0]         func;
      logic signed [FieldW-1:0] x_left;
      logic signed [FieldW-1:0] y_top;
      logic signed [FieldW-1:0] x_right;
      logic signed [FieldW-1:0] y_bottom;
      logic [ColorW-1:0]        color;
   } blit_cmd_type;

   typedef struct {
      logic [ColorW-1:0] read_data;
      logic              out_of_range;
   } blit_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [FuncW-1:0]         req_func;
   logic signed [FieldW-1:0] req_x_left;
   logic signed [FieldW-1:0] req_y_top;
   logic signed [FieldW-1:0] req_x_right;
   logic signed [FieldW-1:0] req_y_bottom;
   logic [ColorW-1:0]        req_pixel_color;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [ColorW-1:0]        rsp_read_data;
   logic                     rsp_out_of_range;

   logic [ColorW-1:0] pixel_shadow [SCREEN_W*SCREEN_H];
   blit_result_type   expected_results_q [$];
   blit_result_type   oldest_result;
   int                fail_count = 0;
   int                last_x = 0;   // a pixel known to hold a recent write
   int                last_y = 0;
   bit                no_gaps = 0;

   framebuffer_rect_fill #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_x_left      (req_x_left),
      .req_y_top       (req_y_top),
      .req_x_right     (req_x_right),
      .req_y_bottom    (req_y_bottom),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic bit on_screen(input int x, input int y);
      return x >= 0 && y >= 0 && x < SCREEN_W && y < SCREEN_H;
   endfunction

   // Applies one command to the shadow store and returns its result.
   function automatic blit_result_type blit_predict(input blit_cmd_type cmd);
      blit_result_type res;
      int x, y, l, t, r, b;
      res.read_data = '0;
      res.out_of_range = 1'b0;
      x = int'(cmd.x_left);
      y = int'(cmd.y_top);
      l = 0;
      t = 0;
      r = SCREEN_W;
      b = SCREEN_H;
      case (cmd.func)
         FUNC_SET: begin
            if (on_screen(x, y)) begin
               pixel_shadow[x + y*SCREEN_W] = cmd.color;
               last_x = x;
               last_y = y;
            end else begin
               res.out_of_range = 1'b1;
            end
         end
         FUNC_READ: begin
            if (on_screen(x, y)) res.read_data = pixel_shadow[x + y*SCREEN_W];
            else res.out_of_range = 1'b1;
         end
         default: begin
            if (cmd.func == FUNC_FILL) begin
               l = (x < 0) ? 0 : x;
               t = (y < 0) ? 0 : y;
               r = (int'(cmd.x_right) > SCREEN_W) ? SCREEN_W : int'(cmd.x_right);
               b = (int'(cmd.y_bottom) > SCREEN_H) ? SCREEN_H : int'(cmd.y_bottom);
            end
            for (int yy = t; yy < b; yy++)
               for (int xx = l; xx < r; xx++)
                  pixel_shadow[xx + yy*SCREEN_W] = cmd.color;
            if (l < r && t < b) begin
               last_x = l;
               last_y = t;
            end
         end
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one item, waits for acceptance and records the expected result.
   task automatic send_command(input blit_cmd_type cmd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= cmd.func;
      req_x_left      <= cmd.x_left;
      req_y_top       <= cmd.y_top;
      req_x_right     <= cmd.x_right;
      req_y_bottom    <= cmd.y_bottom;
      req_pixel_color <= cmd.color;
      do @(posedge clock); while (req_stall);
      expected_results_q.push_back(blit_predict(cmd));
   endtask

   task automatic send_fields(input logic [FuncW-1:0] func, input int xl, input int yt,
                              input int xr, input int yb, input logic [ColorW-1:0] color);
      blit_cmd_type cmd;
      cmd.func     = func;
      cmd.x_left   = FieldW'(xl);
      cmd.y_top    = FieldW'(yt);
      cmd.x_right  = FieldW'(xr);
      cmd.y_bottom = FieldW'(yb);
      cmd.color    = color;
      send_command(cmd);
   endtask

   // Result check; one compare per accepted result item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results_q.size() == 0) begin
            report_mismatch("result item with none expected");
         end else begin
            oldest_result = expected_results_q.pop_front();
            if (rsp_read_data !== oldest_result.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_read_data, oldest_result.read_data));
            if (rsp_out_of_range !== oldest_result.out_of_range)
               report_mismatch($sformatf("out_of_range %b, expected %b",
                                         rsp_out_of_range, oldest_result.out_of_range));
         end
      end
   end

   // Receiver back-pressure: runs of free flow, short stalls and a few long ones.
   initial begin
      int r, len;
      bit val;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            val = 1'b0;
            len = $urandom_range(1, 30);
         end else if (r < 55) begin
            val = 1'b0;
            len = $urandom_range(100, 300);
         end else if (r < 92) begin
            val = 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            val = 1'b1;
            len = $urandom_range(10, 40);
         end
         repeat (len) @(negedge clock) rsp_stall <= val;
      end
   end

   // Whole screen gets written first so that any later read is defined.
   task automatic test_clear_screen();
      send_fields(FUNC_CLEAR, 0, 0, 0, 0, 16'hA5A5);
   endtask

   task automatic test_set_pixel();
      send_fields(FUNC_SET, 0, 0, 0, 0, 16'hFFFF);
      send_fields(FUNC_SET, SCREEN_W-1, SCREEN_H-1, 0, 0, 16'h0000);
      send_fields(FUNC_SET, SCREEN_W-1, 0, 0, 0, 16'h5A5A);
      send_fields(FUNC_SET, 0, SCREEN_H-1, 0, 0, 16'h8001);
      // off-screen: each edge, then the field extremes
      send_fields(FUNC_SET, -1, 0, 0, 0, 16'h1111);
      send_fields(FUNC_SET, 0, -1, 0, 0, 16'h2222);
      send_fields(FUNC_SET, SCREEN_W, 5, 0, 0, 16'h3333);
      send_fields(FUNC_SET, 5, SCREEN_H, 0, 0, 16'h4444);
      send_fields(FUNC_SET, -2048, 2047, 0, 0, 16'h5555);
      send_fields(FUNC_SET, 2047, -2048, 0, 0, 16'h6666);
   endtask

   task automatic test_read_pixel();
      send_fields(FUNC_READ, 0, 0, 0, 0, 16'h0);
      send_fields(FUNC_READ, SCREEN_W-1, SCREEN_H-1, 0, 0, 16'h0);
      send_fields(FUNC_READ, SCREEN_W-1, 0, 0, 0, 16'h0);
      send_fields(FUNC_READ, 0, SCREEN_H-1, 0, 0, 16'h0);
      send_fields(FUNC_READ, -1, -1, 0, 0, 16'hFFFF);
      send_fields(FUNC_READ, 2047, 2047, 2047, 2047, 16'hFFFF);
   endtask

   task automatic test_fill_rect();
      // clamped on all four sides: covers the whole screen
      send_fields(FUNC_FILL, -2048, -2048, 2047, 2047, 16'h1234);
      send_fields(FUNC_READ, 0, 0, 0, 0, 16'h0);
      // empty rectangles: zero width, zero height, reversed, fully off-screen
      send_fields(FUNC_FILL, 10, 10, 10, 20, 16'hDEAD);
      send_fields(FUNC_FILL, 10, 20, 30, 20, 16'hDEAD);
      send_fields(FUNC_FILL, 30, 30, 10, 40, 16'hDEAD);
      send_fields(FUNC_FILL, -20, -20, -1, -1, 16'hDEAD);
      send_fields(FUNC_FILL, SCREEN_W, 0, 2047, 10, 16'hDEAD);
      send_fields(FUNC_READ, 10, 10, 0, 0, 16'h0);
      // clipped at the right and bottom edges
      send_fields(FUNC_FILL, SCREEN_W-10, SCREEN_H-10, 2000, 2000, 16'hBEEF);
      send_fields(FUNC_READ, SCREEN_W-1, SCREEN_H-1, 0, 0, 16'h0);
      send_fields(FUNC_READ, SCREEN_W-11, SCREEN_H-11, 0, 0, 16'h0);
   endtask

   function automatic int clip_field(input int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
   endfunction

   function automatic int rand_field();
      return $urandom_range(0, 4095) - 2048;
   endfunction

   task automatic test_random_commands(input int count);
      int r, kind, xl, yt, xr, yb, clears_left;
      logic [ColorW-1:0] color;
      clears_left = 1;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         color = ColorW'($urandom());
         xr = rand_field();
         yb = rand_field();
         if (clears_left > 0 && r < 2) begin
            clears_left--;
            send_fields(FUNC_CLEAR, rand_field(), rand_field(), xr, yb, color);
         end else if (r < 30) begin
            if ($urandom_range(0, 99) < 85) begin
               xl = $urandom_range(0, SCREEN_W-1);
               yt = $urandom_range(0, SCREEN_H-1);
            end else begin
               xl = rand_field();
               yt = rand_field();
            end
            send_fields(FUNC_SET, xl, yt, xr, yb, color);
         end else if (r < 60) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
               xl = $urandom_range(0, SCREEN_W+15) - 8;
               yt = $urandom_range(0, SCREEN_H+15) - 8;
               xr = xl + $urandom_range(0, 40);
               yb = yt + $urandom_range(0, 16);
            end else if (kind < 8) begin
               xl = rand_field();
               yt = rand_field();
               xr = clip_field(xl + $urandom_range(0, 40));
               yb = clip_field(yt + $urandom_range(0, 16));
            end else begin
               // never covers anything: right not past left
               xl = rand_field();
               yt = rand_field();
               xr = clip_field(xl - $urandom_range(0, 40));
            end
            send_fields(FUNC_FILL, xl, yt, xr, yb, color);
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
               xl = last_x;
               yt = last_y;
            end else if (kind < 85) begin
               xl = $urandom_range(0, SCREEN_W-1);
               yt = $urandom_range(0, SCREEN_H-1);
            end else begin
               xl = rand_field();
               yt = rand_field();
            end
            send_fields(FUNC_READ, xl, yt, xr, yb, color);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_SET;
      req_x_left      = '0;
      req_y_top       = '0;
      req_x_right     = '0;
      req_y_bottom    = '0;
      req_pixel_color = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_clear_screen();
      test_set_pixel();
      test_read_pixel();
      test_fill_rect();
      test_random_commands(RANDOM_ITEMS);

      @(negedge clock) req_valid <= 1'b0;
      while (expected_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Two full-screen passes plus at most one random clear, small fills and stalls.
   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### framebuffer_rect_fill.f
sv/fbrf_pkg.sv
sv/fbrf_front.sv
sv/fbrf_queue.sv
sv/fbrf_back.sv
sv/framebuffer_rect_fill.sv
tb/sv/tb_framebuffer_rect_fill.sv
